// ===== rtl/lcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared types and constants of the linear congruential generator.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ModW    = WordW + 1;            // modulus zero -> 2^32
  localparam int unsigned RedCntW = $clog2(WordW);        // 32 reduce steps
  localparam int unsigned MulCntW = $clog2(WordW + 1);    // 32 mult steps + add
  localparam int unsigned CfgIdxW = 2;

  typedef logic [WordW-1:0]   word_t;
  typedef logic [ModW-1:0]    mod_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // item kinds
  localparam logic KindStep = 1'b0;
  localparam logic KindLoad = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t RegMultiplier = 2'd0;
  localparam cfg_idx_t RegIncrement  = 2'd1;
  localparam cfg_idx_t RegModulus    = 2'd2;

  // reset values (MINSTD)
  localparam word_t ResetMultiplier = 32'd16807;
  localparam word_t ResetIncrement  = 32'd0;
  localparam word_t ResetModulus    = 32'd2147483647;
  localparam word_t ResetValue      = 32'd1;

  // unit handshake between the sequencer and a serial unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

// ===== rtl/lcg_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_in_if
// Input channel: valid/ready with item kind and seed value.
// ----------------------------------------------------------------------------
interface lcg_in_if;
  import lcg_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  word_t seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);

endinterface

// ===== rtl/lcg_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_out_if
// Output channel: valid/ready with the generated value.
// ----------------------------------------------------------------------------
interface lcg_out_if;
  import lcg_pkg::*;

  logic  valid;
  logic  ready;
  word_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

// ===== rtl/lcg_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_reduce
// Bit-serial restoring reduction of a 32-bit word by the modulus,
// one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module lcg_reduce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcg_pkg::unit_req_t req_i,
  input  lcg_pkg::word_t    value_i,
  input  lcg_pkg::mod_t     mod_i,
  output lcg_pkg::unit_rsp_t rsp_o,
  output lcg_pkg::word_t    rem_o
);
  import lcg_pkg::*;

  logic [RedCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  word_t              sh_q, sh_d;
  word_t              rem_q, rem_d;
  mod_t               trial;
  logic               ge;

  assign trial = {rem_q, sh_q[WordW-1]};
  assign ge    = (trial >= mod_i);

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      sh_d   = value_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below modulus, so one subtract suffices
      rem_d = ge ? word_t'(trial - mod_i) : trial[WordW-1:0];
      sh_d  = {sh_q[WordW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == RedCntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

// ===== rtl/lcg_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_mulmod
// Interleaved modular multiply-add: walks the multiplier MSB first,
// r = (2r + a_i * x) mod m, then one final step r = (r + c) mod m.
// Requires x and c below the modulus.
// ----------------------------------------------------------------------------
module lcg_mulmod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcg_pkg::unit_req_t req_i,
  input  lcg_pkg::word_t     mult_i,
  input  lcg_pkg::word_t     x_i,
  input  lcg_pkg::word_t     incr_i,
  input  lcg_pkg::mod_t      mod_i,
  output lcg_pkg::unit_rsp_t rsp_o,
  output lcg_pkg::word_t     res_o
);
  import lcg_pkg::*;

  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  word_t              mult_q, mult_d;
  word_t              x_q, x_d;
  word_t              incr_q, incr_d;
  word_t              acc_q, acc_d;

  logic               dbl;
  logic [ModW-1:0]    base;
  word_t              addend;
  logic [ModW:0]      sum;
  logic [ModW:0]      mod1;
  logic [ModW:0]      mod2;

  assign dbl    = (cnt_q != MulCntW'(WordW));
  assign base   = dbl ? {acc_q, 1'b0} : {1'b0, acc_q};
  assign addend = dbl ? (mult_q[WordW-1] ? x_q : '0) : incr_q;
  assign sum    = {1'b0, base} + {2'b00, addend};
  assign mod1   = {1'b0, mod_i};
  assign mod2   = {mod_i, 1'b0};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    mult_d = mult_q;
    x_d    = x_q;
    incr_d = incr_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      mult_d = mult_i;
      x_d    = x_i;
      incr_d = incr_i;
      acc_d  = '0;
    end else if (busy_q) begin
      // sum is below 3m: subtract m once or twice
      priority if (sum >= mod2) begin
        acc_d = word_t'(sum - mod2);
      end else if (sum >= mod1) begin
        acc_d = word_t'(sum - mod1);
      end else begin
        acc_d = sum[WordW-1:0];
      end
      mult_d = {mult_q[WordW-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (!dbl) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mult_q <= mult_d;
    x_q    <= x_d;
    incr_q <= incr_d;
    acc_q  <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign res_o      = acc_q;

endmodule

// ===== rtl/linear_congruential_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_congruential_generator
// Configurable LCG: a step transaction computes (a*x + c) mod m bit-serially
// and emits it; a load transaction sets the current value.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  in_i    | in  | valid / ready   | kind, seed_value
//  out_o   | out | valid / ready   | value
//  cfg     | in  | cfg_we_i        | cfg_idx_i, cfg_data_i
//
//  A step goes from accept to output valid through 32 multiplier bits in the
//  interleaved mulmod unit, one add of the increment, and the handoff into
//  the output register. After a load or a config write the first step runs
//  a reduction of value and increment first.
//  A stalled output holds the finished result; the next step waits for it.
//  Reset loads the MINSTD parameters and current value 1.
// ----------------------------------------------------------------------------
module linear_congruential_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcg_in_if.sink            in_i,
  lcg_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  lcg_pkg::cfg_idx_t cfg_idx_i,
  input  lcg_pkg::word_t    cfg_data_i
);
  import lcg_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StReduce = 2'd1;
  localparam logic [1:0] StMul    = 2'd2;
  localparam logic [1:0] StHold   = 2'd3;

  logic [1:0] st_q, st_d;
  word_t      mult_q, mult_d;
  word_t      incr_q, incr_d;
  word_t      mod_q, mod_d;
  word_t      cur_q, cur_d;
  word_t      incr_red_q, incr_red_d;
  logic       norm_q, norm_d;
  word_t      out_q, out_d;
  logic       out_valid_q, out_valid_d;

  mod_t       mod_ext;
  logic       accept;
  logic       out_load;
  unit_req_t  red_req;
  unit_req_t  mul_req;
  unit_rsp_t  red_x_rsp;
  unit_rsp_t  red_c_rsp;
  unit_rsp_t  mul_rsp;
  word_t      red_x;
  word_t      red_c;
  word_t      mul_res;
  word_t      mul_x;
  word_t      mul_c;

  // modulus zero stands for 2^32
  assign mod_ext = (mod_q == '0) ? {1'b1, {WordW{1'b0}}} : {1'b0, mod_q};

  assign in_i.ready  = (st_q == StIdle);
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.value = out_q;

  assign mul_x = (st_q == StReduce) ? red_x : cur_q;
  assign mul_c = (st_q == StReduce) ? red_c : incr_red_q;

  always_comb begin
    st_d          = st_q;
    mult_d        = mult_q;
    incr_d        = incr_q;
    mod_d         = mod_q;
    cur_d         = cur_q;
    incr_red_d    = incr_red_q;
    norm_d        = norm_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    out_load      = 1'b0;
    red_req.start = 1'b0;
    mul_req.start = 1'b0;

    unique case (st_q)
      StIdle: begin
        if (accept) begin
          if (in_i.kind == KindLoad) begin
            cur_d  = in_i.seed_value;
            norm_d = 1'b0;
          end else if (norm_q) begin
            mul_req.start = 1'b1;
            st_d          = StMul;
          end else begin
            red_req.start = 1'b1;
            st_d          = StReduce;
          end
        end
      end
      StReduce: begin
        // both reducers run in lockstep
        if (red_x_rsp.done && red_c_rsp.done) begin
          cur_d         = red_x;
          incr_red_d    = red_c;
          norm_d        = 1'b1;
          mul_req.start = 1'b1;
          st_d          = StMul;
        end
      end
      StMul: begin
        if (mul_rsp.done) begin
          if (!out_valid_q || out_o.ready) begin
            out_load = 1'b1;
            st_d     = StIdle;
          end else begin
            st_d = StHold;
          end
        end
      end
      StHold: begin
        if (out_o.ready) begin
          out_load = 1'b1;
          st_d     = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase

    if (out_load) begin
      out_d       = mul_res;
      out_valid_d = 1'b1;
      cur_d       = mul_res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // any register change invalidates the reduced operands
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMultiplier: begin
          mult_d = cfg_data_i;
          norm_d = 1'b0;
        end
        RegIncrement: begin
          incr_d = cfg_data_i;
          norm_d = 1'b0;
        end
        RegModulus: begin
          mod_d  = cfg_data_i;
          norm_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      mult_q      <= ResetMultiplier;
      incr_q      <= ResetIncrement;
      mod_q       <= ResetModulus;
      cur_q       <= ResetValue;
      norm_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      mult_q      <= mult_d;
      incr_q      <= incr_d;
      mod_q       <= mod_d;
      cur_q       <= cur_d;
      norm_q      <= norm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    incr_red_q <= incr_red_d;
    out_q      <= out_d;
  end

  lcg_reduce u_red_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (red_req),
    .value_i (cur_q),
    .mod_i   (mod_ext),
    .rsp_o   (red_x_rsp),
    .rem_o   (red_x)
  );

  lcg_reduce u_red_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (red_req),
    .value_i (incr_q),
    .mod_i   (mod_ext),
    .rsp_o   (red_c_rsp),
    .rem_o   (red_c)
  );

  lcg_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .mult_i (mult_q),
    .x_i    (mul_x),
    .incr_i (mul_c),
    .mod_i  (mod_ext),
    .rsp_o  (mul_rsp),
    .res_o  (mul_res)
  );

endmodule

// ===== rtl/lcg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module lcg_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_kind,
  input logic           out_valid,
  input logic           out_ready,
  input lcg_pkg::word_t out_value
);
  import lcg_pkg::*;

  // a step transaction occupies the block for the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_kind == KindStep) |=> !in_ready)
    else $error("input accepted right after a step transaction");

  // a load transaction never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_kind == KindLoad) && !out_valid |=> !out_valid)
    else $error("result appeared after a load transaction");

  // a new result comes only from a step in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled result dropped or changed");

endmodule

bind linear_congruential_generator lcg_checker u_lcg_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_kind   (in_i.kind),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_value (out_o.value)
);

// ===== tb/tb_linear_congruential_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_congruential_generator
// Self-checking bench: steps and seed loads go in over the input channel,
// and each generated value is checked against a bit-exact next-value
// predictor. Register settings change between phases while the block is
// quiet. Both channels idle and stall at random, with one long output hold.
// ----------------------------------------------------------------------------
module tb_linear_congruential_generator;
  import lcg_pkg::*;

  localparam int       SettleCycles  = 100;   // longer than a step after a load
  localparam int       RxHoldCycles  = 400;
  localparam int       WatchdogLimit = 3000;
  localparam int       PhaseItems    = 210;
  // index past the end of the register map, writes to it are dropped
  localparam cfg_idx_t RegUnused     = 2'd3;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_t cfg_idx_i;
  word_t    cfg_data_i;

  lcg_in_if  in_ch ();
  lcg_out_if out_ch ();

  linear_congruential_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  word_t gen_mult;
  word_t gen_incr;
  word_t gen_mod;
  word_t gen_value;
  word_t expected_values[$];

  int mismatches  = 0;
  int quiet_cycles = 0;
  bit rx_hold_req = 1'b0;

  function automatic word_t lcg_advance(word_t x);
    logic [63:0] acc;
    acc = {32'd0, gen_mult} * {32'd0, x} + {32'd0, gen_incr};
    // modulus zero stands for 2^32
    if (gen_mod == '0) return acc[31:0];
    return word_t'(acc % {32'd0, gen_mod});
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'($urandom_range(1, 16));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t pick_seed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return gen_mod + word_t'($urandom_range(3));   // at or past modulus unless the sum wraps
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(9))
      0, 1, 2, 3: return 0;
      4, 5, 6, 7: return $urandom_range(1, 6);
      default:    return $urandom_range(7, 45);
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(logic item_kind, word_t seed);
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= item_kind;
    in_ch.seed_value <= seed;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    if (item_kind == KindLoad) begin
      gen_value = seed;
    end else begin
      gen_value = lcg_advance(gen_value);
      expected_values.push_back(gen_value);
    end
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_ch.valid      <= 1'b0;
      in_ch.seed_value <= word_t'($urandom);
    end
  endtask

  // hold the input until every pending value is out, then let the block settle
  task automatic drain();
    idle_input(1);
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, word_t data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      RegMultiplier: gen_mult = data;
      RegIncrement:  gen_incr = data;
      RegModulus:    gen_mod  = data;
      default: ;
    endcase
  endtask

  task automatic configure(word_t mult, word_t incr, word_t modulus);
    drain();
    write_reg(RegMultiplier, mult);
    write_reg(RegIncrement, incr);
    write_reg(RegModulus, modulus);
  endtask

  task automatic run_random(int count, int load_pct, bit with_gaps);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(99) < load_pct) send_item(KindLoad, pick_seed());
        else send_item(KindStep, word_t'($urandom));
        sent++;
      end
      gap = with_gaps ? pick_gap() : 0;
      if (gap > 0) idle_input(gap);
    end
  endtask

  // ------------------------------------------------------------------ tests

  // MINSTD sequence from the reset seed of 1
  task automatic test_reset_parameters();
    repeat (3) send_item(KindStep, '0);
  endtask

  task automatic test_field_extremes();
    configure('1, '1, '1);
    send_item(KindLoad, 32'hFFFF_FFFE);
    send_item(KindStep, '0);
    send_item(KindLoad, '1);                // seed equal to modulus
    send_item(KindStep, '0);
    send_item(KindLoad, '0);
    send_item(KindStep, '1);
    // modulus zero wraps at 2^32
    configure('1, '1, '0);
    send_item(KindLoad, '1);
    send_item(KindStep, '0);
    send_item(KindStep, '0);
    // modulus one pins every value to zero
    configure(32'h8000_0001, 32'h1234_5678, 32'd1);
    send_item(KindStep, '0);
    drain();
    write_reg(RegUnused, '1);
    configure('0, 32'd5, 32'd7);
    send_item(KindLoad, 32'd100);           // seed well past modulus
    send_item(KindStep, '0);
    send_item(KindStep, '0);
    drain();
    write_reg(RegUnused, '0);
  endtask

  // stall the output long enough to back the block up into its input
  task automatic test_output_backpressure();
    configure(ResetMultiplier, ResetIncrement, ResetModulus);
    send_item(KindLoad, word_t'($urandom));
    idle_input(1);
    rx_hold_req = 1'b1;
    repeat (40) send_item(KindStep, word_t'($urandom));
    drain();
  endtask

  task automatic test_random_sequences();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       configure(ResetMultiplier, ResetIncrement, ResetModulus);
        1:       configure('1, '1, '1);
        2:       configure(pick_word(), pick_word(), '0);
        3:       configure(word_t'($urandom), pick_word(), word_t'($urandom_range(1, 16)));
        4:       configure('0, word_t'($urandom), word_t'($urandom));
        default: configure(pick_word(), pick_word(), pick_word());
      endcase
      if (phase == 5) write_reg(RegUnused, word_t'($urandom));
      run_random(PhaseItems, 10, phase != 3);
    end
  endtask

  // ---------------------------------------------------------------- checkers

  initial begin : receiver
    int stall_pct;
    int span;
    out_ch.ready = 1'b0;
    stall_pct    = 0;
    span         = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        rx_hold_req = 1'b0;
        repeat (RxHoldCycles - 1) @(negedge clk_i);
      end else begin
        if (span == 0) begin
          span = $urandom_range(16, 96);
          case ($urandom_range(3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 60;
            default: stall_pct = 95;
          endcase
        end
        span--;
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_values.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected value: expected none actual %h", $time, out_ch.value);
      end else begin
        want = expected_values.pop_front();
        if (out_ch.value !== want) begin
          mismatches++;
          $display("%0t: value mismatch: expected %h actual %h", $time, want, out_ch.value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb_linear_congruential_generator NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = RegMultiplier;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KindStep;
    in_ch.seed_value = '0;
    gen_mult         = ResetMultiplier;
    gen_incr         = ResetIncrement;
    gen_mod          = ResetModulus;
    gen_value        = ResetValue;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_parameters();
    test_field_extremes();
    test_output_backpressure();
    test_random_sequences();
    drain();

    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("tb_linear_congruential_generator OK");
    end else begin
      $display("tb_linear_congruential_generator NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lcg_pkg.sv
rtl/lcg_in_if.sv
rtl/lcg_out_if.sv
rtl/lcg_reduce.sv
rtl/lcg_mulmod.sv
rtl/linear_congruential_generator.sv
rtl/lcg_checker.sv
tb/tb_linear_congruential_generator.sv
